[rtl/sqtc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the scale/quaternion/translation matrix core.
// No dependencies; used by scale_quaternion_translate_compose_core.

package sqtc_pkg;

    // Field widths
    localparam int unsigned QUAT_W  = 16;   // Q2.14
    localparam int unsigned SCALE_W = 16;   // Q8.8
    localparam int unsigned FIX_W   = 32;   // Q16.16
    localparam int unsigned PROD_W  = 32;   // Q2.14 * Q2.14 -> Q4.28
    localparam int unsigned ELEM_W  = 35;   // rotation element, Q4.28 with headroom
    localparam int unsigned SCL_W   = ELEM_W + SCALE_W;  // scaled element, Q.36
    localparam int unsigned TRUNC_SH = 20;  // Q.36 -> Q16.16

    // Fixed-point constants
    localparam logic signed [ELEM_W-1:0] ONE_Q28 = ELEM_W'(64'sd1 << 28);
    localparam logic signed [FIX_W-1:0]  ONE_Q16 = FIX_W'(32'sd65536);
    localparam logic signed [FIX_W-1:0]  ZERO_Q16 = '0;
    localparam logic signed [FIX_W-1:0]  SAT_MAX = {1'b0, {(FIX_W-1){1'b1}}};
    localparam logic signed [FIX_W-1:0]  SAT_MIN = {1'b1, {(FIX_W-1){1'b0}}};

    // Row codes
    typedef logic [1:0] row_t;
    localparam row_t ROW_X    = 2'd0;
    localparam row_t ROW_Y    = 2'd1;
    localparam row_t ROW_Z    = 2'd2;
    localparam row_t ROW_MOVE = 2'd3;

    // Operands of one rotation element: 2*(p*q +/- r*s), or 1 - that on the diagonal
    typedef struct packed {
        logic signed [QUAT_W-1:0] p;
        logic signed [QUAT_W-1:0] q;
        logic signed [QUAT_W-1:0] r;
        logic signed [QUAT_W-1:0] s;
        logic                     sub;   // p*q - r*s
        logic                     diag;  // 1 - 2*(...)
    } elem_ops_t;

endpackage

[rtl/scale_quaternion_translate_compose_core.sv]
`timescale 1ns / 1ps
// Top level: builds the row-vector world matrix Scale*Rotation*Translation.
// Depends on sqtc_pkg for widths, row codes and fixed-point constants.

// A transaction is accepted when start is high and busy is low. It produces
// four row results, row 0 first, on consecutive cycles, each marked by strobe
// for one cycle; rows pass stages A to D and the output register. The receiver
// cannot stall, so results are never held. busy stays high after an accept
// while the row sequencer feeds the rotation rows to the one shared set of
// six 16x16 multipliers, one row per cycle, and drops as the translation row
// issues, when a new transaction can be accepted. The quaternion is not
// normalized, products truncate toward minus infinity, rotation rows saturate.

module scale_quaternion_translate_compose_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [15:0]       scale_x,
    input  logic signed [15:0]       scale_y,
    input  logic signed [15:0]       scale_z,
    input  logic signed [15:0]       quat_x,
    input  logic signed [15:0]       quat_y,
    input  logic signed [15:0]       quat_z,
    input  logic signed [15:0]       quat_w,
    input  logic signed [31:0]       move_x,
    input  logic signed [31:0]       move_y,
    input  logic signed [31:0]       move_z,
    output logic                     strobe,
    output logic [1:0]               row_index,
    output logic signed [31:0]       col0,
    output logic signed [31:0]       col1,
    output logic signed [31:0]       col2,
    output logic signed [31:0]       col3,
    output logic                     last
);

    localparam int unsigned QW = sqtc_pkg::QUAT_W;
    localparam int unsigned SW = sqtc_pkg::SCALE_W;
    localparam int unsigned FW = sqtc_pkg::FIX_W;
    localparam int unsigned PW = sqtc_pkg::PROD_W;
    localparam int unsigned EW = sqtc_pkg::ELEM_W;
    localparam int unsigned XW = sqtc_pkg::SCL_W;

    logic accept;

    // Held transaction
    logic signed [SW-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [QW-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [FW-1:0] mx_reg, my_reg, mz_reg;

    // Row sequencer
    logic           seq_act_reg, seq_act_next;
    sqtc_pkg::row_t seq_row_reg, seq_row_next;

    // Stage A: operands
    logic                  a_vld_reg;
    sqtc_pkg::row_t        a_row_reg;
    sqtc_pkg::elem_ops_t   a_ops_reg [3];
    sqtc_pkg::elem_ops_t   a_ops_next [3];
    logic signed [SW-1:0]  a_scale_reg, a_scale_next;
    logic signed [FW-1:0]  a_move_reg [3];

    // Stage B: products
    logic                  b_vld_reg;
    sqtc_pkg::row_t        b_row_reg;
    logic signed [PW-1:0]  b_pq_reg [3];
    logic signed [PW-1:0]  b_rs_reg [3];
    logic                  b_sub_reg [3];
    logic                  b_diag_reg [3];
    logic signed [SW-1:0]  b_scale_reg;
    logic signed [FW-1:0]  b_move_reg [3];

    // Stage C: rotation elements
    logic                  c_vld_reg;
    sqtc_pkg::row_t        c_row_reg;
    logic signed [EW-1:0]  c_elem_reg [3];
    logic signed [EW-1:0]  c_elem_next [3];
    logic signed [SW-1:0]  c_scale_reg;
    logic signed [FW-1:0]  c_move_reg [3];

    // Stage D: scaled elements
    logic                  d_vld_reg;
    sqtc_pkg::row_t        d_row_reg;
    logic signed [XW-1:0]  d_prod_reg [3];
    logic signed [FW-1:0]  d_move_reg [3];

    // Output stage
    logic                  o_vld_reg;
    sqtc_pkg::row_t        o_row_reg;
    logic signed [FW-1:0]  o_col_reg [4];
    logic signed [FW-1:0]  o_col_next [4];
    logic                  o_last_reg;

    assign busy   = seq_act_reg && (seq_row_reg != sqtc_pkg::ROW_MOVE);
    assign accept = start && !busy;

    // Capture the transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg <= scale_x;
            sy_reg <= scale_y;
            sz_reg <= scale_z;
            qx_reg <= quat_x;
            qy_reg <= quat_y;
            qz_reg <= quat_z;
            qw_reg <= quat_w;
            mx_reg <= move_x;
            my_reg <= move_y;
            mz_reg <= move_z;
        end
    end

    // Row sequencer: one row issued per cycle
    always_comb
    begin
        seq_act_next = seq_act_reg;
        seq_row_next = seq_row_reg;
        if (accept)
        begin
            seq_act_next = 1'b1;
            seq_row_next = sqtc_pkg::ROW_X;
        end
        else if (seq_act_reg)
        begin
            if (seq_row_reg == sqtc_pkg::ROW_MOVE)
            begin
                seq_act_next = 1'b0;
            end
            else
            begin
                seq_row_next = seq_row_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_act_reg <= 1'b0;
            seq_row_reg <= sqtc_pkg::ROW_X;
        end
        else
        begin
            seq_act_reg <= seq_act_next;
            seq_row_reg <= seq_row_next;
        end
    end

    // Operand select for the issued row
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            a_ops_next[j] = '0;
        end
        a_scale_next = '0;
        case (seq_row_reg)
            sqtc_pkg::ROW_X:
            begin
                a_ops_next[0] = '{p: qy_reg, q: qy_reg, r: qz_reg, s: qz_reg,
                                  sub: 1'b0, diag: 1'b1};
                a_ops_next[1] = '{p: qx_reg, q: qy_reg, r: qw_reg, s: qz_reg,
                                  sub: 1'b0, diag: 1'b0};
                a_ops_next[2] = '{p: qx_reg, q: qz_reg, r: qw_reg, s: qy_reg,
                                  sub: 1'b1, diag: 1'b0};
                a_scale_next  = sx_reg;
            end
            sqtc_pkg::ROW_Y:
            begin
                a_ops_next[0] = '{p: qx_reg, q: qy_reg, r: qw_reg, s: qz_reg,
                                  sub: 1'b1, diag: 1'b0};
                a_ops_next[1] = '{p: qx_reg, q: qx_reg, r: qz_reg, s: qz_reg,
                                  sub: 1'b0, diag: 1'b1};
                a_ops_next[2] = '{p: qy_reg, q: qz_reg, r: qw_reg, s: qx_reg,
                                  sub: 1'b0, diag: 1'b0};
                a_scale_next  = sy_reg;
            end
            sqtc_pkg::ROW_Z:
            begin
                a_ops_next[0] = '{p: qx_reg, q: qz_reg, r: qw_reg, s: qy_reg,
                                  sub: 1'b0, diag: 1'b0};
                a_ops_next[1] = '{p: qy_reg, q: qz_reg, r: qw_reg, s: qx_reg,
                                  sub: 1'b1, diag: 1'b0};
                a_ops_next[2] = '{p: qx_reg, q: qx_reg, r: qy_reg, s: qy_reg,
                                  sub: 1'b0, diag: 1'b1};
                a_scale_next  = sz_reg;
            end
            default:
            begin
                // translation row: no rotation work
                a_scale_next = '0;
            end
        endcase
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= seq_act_reg;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            o_vld_reg <= d_vld_reg;
        end
    end

    // Stage A register
    always_ff @(posedge clk)
    begin
        a_row_reg     <= seq_row_reg;
        a_ops_reg     <= a_ops_next;
        a_scale_reg   <= a_scale_next;
        a_move_reg[0] <= mx_reg;
        a_move_reg[1] <= my_reg;
        a_move_reg[2] <= mz_reg;
    end

    // Stage B: six quaternion products
    always_ff @(posedge clk)
    begin
        b_row_reg   <= a_row_reg;
        b_scale_reg <= a_scale_reg;
        b_move_reg  <= a_move_reg;
        for (int j = 0; j < 3; j++)
        begin
            b_pq_reg[j]   <= a_ops_reg[j].p * a_ops_reg[j].q;
            b_rs_reg[j]   <= a_ops_reg[j].r * a_ops_reg[j].s;
            b_sub_reg[j]  <= a_ops_reg[j].sub;
            b_diag_reg[j] <= a_ops_reg[j].diag;
        end
    end

    // Stage C: element = 2*(pq +/- rs), or 1 - that on the diagonal
    always_comb
    begin
        logic signed [PW:0]   sum;
        logic signed [EW-1:0] dbl;
        for (int j = 0; j < 3; j++)
        begin
            sum = b_sub_reg[j] ? ((PW+1)'(b_pq_reg[j]) - (PW+1)'(b_rs_reg[j]))
                               : ((PW+1)'(b_pq_reg[j]) + (PW+1)'(b_rs_reg[j]));
            dbl = EW'(sum) <<< 1;
            c_elem_next[j] = b_diag_reg[j] ? (sqtc_pkg::ONE_Q28 - dbl) : dbl;
        end
    end

    always_ff @(posedge clk)
    begin
        c_row_reg   <= b_row_reg;
        c_scale_reg <= b_scale_reg;
        c_move_reg  <= b_move_reg;
        c_elem_reg  <= c_elem_next;
    end

    // Stage D: apply axis scale
    always_ff @(posedge clk)
    begin
        d_row_reg  <= c_row_reg;
        d_move_reg <= c_move_reg;
        for (int j = 0; j < 3; j++)
        begin
            d_prod_reg[j] <= XW'(c_elem_reg[j]) * XW'(c_scale_reg);
        end
    end

    // Output stage: truncate, saturate, or pass translation
    always_comb
    begin
        logic signed [XW-1:0] shifted;
        for (int j = 0; j < 3; j++)
        begin
            shifted = d_prod_reg[j] >>> sqtc_pkg::TRUNC_SH;
            if (shifted > XW'(sqtc_pkg::SAT_MAX))
            begin
                o_col_next[j] = sqtc_pkg::SAT_MAX;
            end
            else if (shifted < XW'(sqtc_pkg::SAT_MIN))
            begin
                o_col_next[j] = sqtc_pkg::SAT_MIN;
            end
            else
            begin
                o_col_next[j] = FW'(shifted);
            end
        end
        o_col_next[3] = sqtc_pkg::ZERO_Q16;
        if (d_row_reg == sqtc_pkg::ROW_MOVE)
        begin
            o_col_next[0] = d_move_reg[0];
            o_col_next[1] = d_move_reg[1];
            o_col_next[2] = d_move_reg[2];
            o_col_next[3] = sqtc_pkg::ONE_Q16;
        end
    end

    always_ff @(posedge clk)
    begin
        o_row_reg  <= d_row_reg;
        o_col_reg  <= o_col_next;
        o_last_reg <= (d_row_reg == sqtc_pkg::ROW_MOVE);
    end

    assign strobe    = o_vld_reg;
    assign row_index = o_row_reg;
    assign col0      = o_col_reg[0];
    assign col1      = o_col_reg[1];
    assign col2      = o_col_reg[2];
    assign col3      = o_col_reg[3];
    assign last      = o_last_reg;

`ifndef ASSERT_OFF
    // An accepted transaction keeps the sequencer busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    // Rotation rows carry a zero last column and never end the run
    a_rot_row: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && row_index != sqtc_pkg::ROW_MOVE) |-> (!last && col3 == sqtc_pkg::ZERO_Q16))
        else $error("rotation row with bad last column or last flag");

    // Translation row ends the run with 1.0 in the last column
    a_move_row: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && row_index == sqtc_pkg::ROW_MOVE) |-> (last && col3 == sqtc_pkg::ONE_Q16))
        else $error("translation row malformed");

    // Rows of a transaction follow on consecutive cycles in order
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && row_index != sqtc_pkg::ROW_MOVE)
            |=> (strobe && row_index == $past(row_index) + 2'd1))
        else $error("row sequence broken");
`endif

endmodule
